@@ hw/rtl/rwz_pkg.sv @@
// Shared widths and constants for the rolling window z-score block.
// No dependencies; imported by every module of the block.
package rwz_pkg;

    localparam int SAMPLE_W   = 24;   // input sample
    localparam int W_W        = 7;    // window length register
    localparam int MEAN_W     = 32;
    localparam int DEV_W      = 32;
    localparam int Z_W        = 17;
    localparam int CW         = 64;   // shared compare-subtract width
    localparam int ZN_W       = 46;   // |256*x - mean| * 4096
    localparam int IN_DATA_W  = 24;   // sample, byte aligned
    localparam int OUT_DATA_W = 88;   // mean, deviation, zscore, zero pad

    localparam logic [W_W-1:0] WL_RESET = 7'd20;

endpackage

@@ hw/rtl/rwz_csub.sv @@
// Shared compare-subtract unit, reused for every divide and square root step.
// Depends on rwz_pkg.
module rwz_csub (
    input  logic [rwz_pkg::CW-1:0] a,
    input  logic [rwz_pkg::CW-1:0] b,
    output logic                   ge,
    output logic [rwz_pkg::CW-1:0] diff
);
    import rwz_pkg::*;

    logic [CW:0] wide;

    assign wide = {1'b0, a} - {1'b0, b};
    assign ge   = ~wide[CW];
    assign diff = wide[CW-1:0];

endmodule

@@ hw/rtl/rolling_window_zscore.sv @@
// Rolling window mean, sample deviation and z-score over a stream of samples.
// Depends on rwz_pkg and rwz_csub.
//
// Usage:
//   Input channel (s_axis_*): one item per sample; tdata holds the signed
//   24-bit sample, tuser is the series start flag, which clears the count,
//   sums and write slot before the sample is taken.
//   Output channel (m_axis_*): one item per input item with mean, deviation
//   and z-score in tdata and the window full flag in tuser.
//   Config channel (cfg_*): writes the window length and restarts the
//   series; taken only in idle with no input item offered.
// Sequencing:
//   Not-full window: read the old sample, update the sums, output.
//   Full window: multiply steps, then the divide and root steps below;
//   a window of one ends after the mean divide, a zero deviation after
//   the square root. The single compare-subtract unit runs mean divide,
//   variance divide, square root and z-score divide one bit per cycle.
//   The input is not ready while an item is in work.
// Reset: window length returns to 20, sums and count clear; the window
//   memory is not cleared (a slot is read only after it was written).
// Stall: the result sits in an output register; the next item is accepted
//   and worked on, and waits in its last step only if that register is full.
module rolling_window_zscore #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [23:0] sample
    input  logic [rwz_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] series_start
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] mean_out, [63:32] deviation_out, [80:64] zscore_out, rest zero
    output logic [rwz_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // [0] window_full
    output logic                               m_axis_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rwz_pkg::W_W-1:0]            cfg_data
);
    import rwz_pkg::*;

    localparam int LOG_W  = $clog2(MAX_WINDOW);
    localparam int SLOT_W = LOG_W;
    localparam int SUM_W  = SAMPLE_W + LOG_W;
    localparam int SQ_W   = 2 * SAMPLE_W - 1 + LOG_W;
    localparam int SB_W   = 2 * SUM_W;
    localparam int WA_W   = W_W + SQ_W;
    localparam int NUM_W  = WA_W + 16;
    localparam int MD_W   = SUM_W + 8;
    localparam int DVD_W  = NUM_W;
    localparam int DD_W   = 3 * W_W;
    localparam int PR_W   = 2 * SAMPLE_W;
    localparam int CNT_W  = $clog2(DVD_W + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RD    = 4'd1;
    localparam logic [3:0] ST_UPA   = 4'd2;
    localparam logic [3:0] ST_UPB   = 4'd3;
    localparam logic [3:0] ST_UPC   = 4'd4;
    localparam logic [3:0] ST_M1    = 4'd5;
    localparam logic [3:0] ST_M2    = 4'd6;
    localparam logic [3:0] ST_M3    = 4'd7;
    localparam logic [3:0] ST_M4    = 4'd8;
    localparam logic [3:0] ST_DMEAN = 4'd9;
    localparam logic [3:0] ST_DVAR  = 4'd10;
    localparam logic [3:0] ST_SQRT  = 4'd11;
    localparam logic [3:0] ST_DZ    = 4'd12;
    localparam logic [3:0] ST_FIN   = 4'd13;

    logic [3:0]               state_reg, state_next;
    logic [W_W-1:0]           wl_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [W_W-1:0]           cnt_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic                     ov_reg;

    logic signed [SAMPLE_W-1:0] x_reg, old_reg;
    logic                     full_reg, fa_reg, zneg_reg;
    logic [PR_W-1:0]          prod_reg;
    logic [WA_W-1:0]          wa_reg, num_reg;
    logic [SB_W-1:0]          sb_reg;
    logic [DD_W-1:0]          dd_reg;
    logic [CW-1:0]            rem_reg, quo_reg, dvs_reg, bit_reg;
    logic [DVD_W-1:0]         dvd_reg;
    logic [CNT_W-1:0]         it_reg;
    logic [MEAN_W-1:0]        mean_reg, om_reg;
    logic [DEV_W-1:0]         dev_reg, od_reg;
    logic [Z_W-1:0]           z_reg, oz_reg;
    logic                     of_reg;

    logic signed [SAMPLE_W-1:0] mem [MAX_WINDOW];

    logic [W_W-1:0]           w;
    logic                     s_acc, c_acc, o_load;
    logic [SLOT_W-1:0]        slot_fix;
    logic [SLOT_W:0]          slot_inc;
    logic [SUM_W-1:0]         sum_mag;
    logic [SAMPLE_W-1:0]      x_mag, old_mag;
    logic [CW-1:0]            csu_a, csu_b, csu_diff;
    logic                     csu_ge;
    logic signed [ZN_W-13:0]  zd;
    logic [ZN_W-13:0]         zd_mag;
    logic                     dv_step;

    // effective window: zero means one, clamp to the store depth
    always_comb
    begin
        if (wl_reg == '0)
            w = W_W'(1);
        else if (int'(wl_reg) > MAX_WINDOW)
            w = W_W'(MAX_WINDOW);
        else
            w = wl_reg;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = (state_reg == ST_IDLE) && !s_axis_tvalid;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign c_acc         = cfg_valid && cfg_ready;
    assign o_load        = (state_reg == ST_FIN) && (!ov_reg || m_axis_tready);

    assign slot_fix = ({1'b0, slot_reg} >= (SLOT_W + 1)'(w)) ? '0 : slot_reg;
    assign slot_inc = {1'b0, slot_reg} + (SLOT_W + 1)'(1);
    assign sum_mag  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign x_mag    = x_reg[SAMPLE_W-1] ? SAMPLE_W'(-x_reg) : SAMPLE_W'(x_reg);
    assign old_mag  = old_reg[SAMPLE_W-1] ? SAMPLE_W'(-old_reg) : SAMPLE_W'(old_reg);

    assign zd     = {{2{x_reg[SAMPLE_W-1]}}, x_reg, 8'd0}
                  - {{2{mean_reg[MEAN_W-1]}}, $signed(mean_reg)};
    assign zd_mag = zd[ZN_W-13] ? (ZN_W - 12)'(-zd) : (ZN_W - 12)'(zd);

    assign dv_step = (state_reg == ST_DMEAN) || (state_reg == ST_DVAR)
                  || (state_reg == ST_DZ);

    // divide: shift in next dividend bit; square root: test res|bit
    always_comb
    begin
        if (dv_step)
        begin
            csu_a = {rem_reg[CW-2:0], dvd_reg[DVD_W-1]};
            csu_b = dvs_reg;
        end
        else
        begin
            csu_a = rem_reg;
            csu_b = quo_reg | bit_reg;
        end
    end

    rwz_csub u_csub (
        .a    (csu_a),
        .b    (csu_b),
        .ge   (csu_ge),
        .diff (csu_diff)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_acc) state_next = ST_RD;
            ST_RD:    state_next = ST_UPA;
            ST_UPA:   state_next = ST_UPB;
            ST_UPB:   state_next = ST_UPC;
            ST_UPC:   state_next = (cnt_reg >= w) ? ST_M1 : ST_FIN;
            ST_M1:    state_next = ST_M2;
            ST_M2:    state_next = ST_M3;
            ST_M3:    state_next = ST_M4;
            ST_M4:    state_next = ST_DMEAN;
            ST_DMEAN: if (it_reg == '0) state_next = (w < W_W'(2)) ? ST_FIN : ST_DVAR;
            ST_DVAR:  if (it_reg == '0) state_next = ST_SQRT;
            ST_SQRT:  if (it_reg == '0) state_next = (quo_reg[DEV_W-1:0] == '0) ? ST_FIN : ST_DZ;
            ST_DZ:    if (it_reg == '0) state_next = ST_FIN;
            ST_FIN:   if (o_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control state and running sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wl_reg    <= WL_RESET;
            sum_reg   <= '0;
            sq_reg    <= '0;
            cnt_reg   <= '0;
            slot_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (o_load)
                ov_reg <= 1'b1;
            else if (m_axis_tready)
                ov_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (c_acc)
                        wl_reg <= cfg_data;
                    if (c_acc || (s_acc && s_axis_tuser))
                    begin
                        sum_reg  <= '0;
                        sq_reg   <= '0;
                        cnt_reg  <= '0;
                        slot_reg <= '0;
                    end
                end
                ST_RD:
                    slot_reg <= slot_fix;
                ST_UPA:
                begin
                    sum_reg <= sum_reg + SUM_W'(x_reg)
                             - (full_reg ? SUM_W'(old_reg) : SUM_W'(0));
                    slot_reg <= (slot_inc >= (SLOT_W + 1)'(w)) ? '0
                              : slot_inc[SLOT_W-1:0];
                    if (cnt_reg < w)
                        cnt_reg <= cnt_reg + W_W'(1);
                end
                ST_UPB:
                    sq_reg <= sq_reg - SQ_W'(prod_reg);
                ST_UPC:
                    sq_reg <= sq_reg + SQ_W'(prod_reg);
                default:
                begin
                end
            endcase
        end
    end

    // window store
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RD)
            old_reg <= mem[slot_fix];
        if (state_reg == ST_UPA)
            mem[slot_reg] <= x_reg;
    end

    // datapath and sequencer payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (s_acc)
                    x_reg <= $signed(s_axis_tdata[SAMPLE_W-1:0]);
            ST_RD:
                full_reg <= (cnt_reg >= w);
            ST_UPA:
                prod_reg <= full_reg ? PR_W'(old_mag) * PR_W'(old_mag) : '0;
            ST_UPB:
                prod_reg <= PR_W'(x_mag) * PR_W'(x_mag);
            ST_UPC:
            begin
                mean_reg <= '0;
                dev_reg  <= '0;
                z_reg    <= '0;
                fa_reg   <= (cnt_reg >= w);
            end
            ST_M1:
                wa_reg <= WA_W'(w) * WA_W'(sq_reg);
            ST_M2:
                sb_reg <= SB_W'(sum_mag) * SB_W'(sum_mag);
            ST_M3:
            begin
                num_reg <= wa_reg - WA_W'(sb_reg);
                dd_reg  <= DD_W'(w) * DD_W'(w);
            end
            ST_M4:
            begin
                dd_reg  <= dd_reg * DD_W'(w - W_W'(1));
                dvd_reg <= DVD_W'({sum_mag, 8'd0}) << (DVD_W - MD_W);
                dvs_reg <= CW'(w);
                rem_reg <= '0;
                quo_reg <= '0;
                it_reg  <= CNT_W'(MD_W);
            end
            ST_DMEAN, ST_DVAR, ST_DZ:
            begin
                if (it_reg != '0)
                begin
                    rem_reg <= csu_ge ? csu_diff : csu_a;
                    quo_reg <= {quo_reg[CW-2:0], csu_ge};
                    dvd_reg <= dvd_reg << 1;
                    it_reg  <= it_reg - CNT_W'(1);
                end
                else if (state_reg == ST_DMEAN)
                begin
                    mean_reg <= sum_reg[SUM_W-1] ? MEAN_W'(-quo_reg[MEAN_W-1:0])
                                                 : quo_reg[MEAN_W-1:0];
                    dvd_reg  <= {num_reg, 16'd0};
                    dvs_reg  <= CW'(dd_reg);
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    it_reg   <= CNT_W'(NUM_W);
                end
                else if (state_reg == ST_DVAR)
                begin
                    rem_reg <= quo_reg;
                    quo_reg <= '0;
                    bit_reg <= CW'(1) << (CW - 2);
                    it_reg  <= CNT_W'(CW / 2);
                end
                else
                begin
                    // saturate to the 17-bit signed range
                    if (!zneg_reg)
                        z_reg <= (quo_reg > CW'(65535)) ? Z_W'(65535)
                                                        : quo_reg[Z_W-1:0];
                    else
                        z_reg <= (quo_reg > CW'(65536)) ? Z_W'(65536)
                                                        : Z_W'(-quo_reg[Z_W-1:0]);
                end
            end
            ST_SQRT:
            begin
                if (it_reg != '0)
                begin
                    if (csu_ge)
                    begin
                        rem_reg <= csu_diff;
                        quo_reg <= (quo_reg >> 1) | bit_reg;
                    end
                    else
                        quo_reg <= quo_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                    it_reg  <= it_reg - CNT_W'(1);
                end
                else
                begin
                    dev_reg  <= quo_reg[DEV_W-1:0];
                    zneg_reg <= zd[ZN_W-13];
                    dvd_reg  <= DVD_W'({zd_mag, 12'd0}) << (DVD_W - ZN_W);
                    dvs_reg  <= CW'(quo_reg[DEV_W-1:0]);
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    it_reg   <= CNT_W'(ZN_W);
                end
            end
            default:
            begin
            end
        endcase
        if (o_load)
        begin
            om_reg <= mean_reg;
            od_reg <= dev_reg;
            oz_reg <= z_reg;
            of_reg <= fa_reg;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - MEAN_W - DEV_W - Z_W){1'b0}},
                            oz_reg, od_reg, om_reg};
    assign m_axis_tuser  = of_reg;

endmodule

@@ hw/rtl/rwz_chk.sv @@
// Port-level checker for rolling_window_zscore, attached by bind.
// Depends on rwz_pkg.
module rwz_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [rwz_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tuser
);
    import rwz_pkg::*;

    // one item at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after accept");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result dropped or changed");

    // results before the window fills are all zero
    a_notfull: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("nonzero result before window full");

    // zero deviation forces zero z-score
    a_zdev: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[63:32] == '0 |-> m_axis_tdata[80:64] == '0)
        else $error("z-score with zero deviation");

endmodule

bind rolling_window_zscore rwz_chk u_rwz_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ bench/rolling_window_zscore_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for rolling_window_zscore: sends samples, predicts mean,
// deviation, z-score and fill flag per item, checks each output item in order.
// Depends on rwz_pkg and the rolling_window_zscore RTL.
module rolling_window_zscore_test;
    import rwz_pkg::*;

    localparam int  MAXW        = 64;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  SETTLE      = 250;      // a bit over the full-window latency
    localparam logic [W_W-1:0] WL_MIN = 7'd1;
    localparam logic [W_W-1:0] WL_MAX = 7'd64;
    localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = -24'sh800000;

    typedef enum int {IDLE_SEND_HEAVY, IDLE_RECV_HEAVY, IDLE_NONE} idle_mode_t;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [DEV_W-1:0]  dev;
        logic [Z_W-1:0]    z;
        logic              full;
    } stats_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic m_axis_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [W_W-1:0] cfg_data = '0;

    rolling_window_zscore #(.MAX_WINDOW(MAXW)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // ---- predictor state: window store, running sums, fill count ----
    logic signed [SAMPLE_W-1:0] win_mem [MAXW];
    longint      win_sum;
    logic [63:0] win_sqsum;
    int          win_count;
    int          win_slot;
    logic [W_W-1:0] win_len;

    stats_t     pending_stats[$];
    idle_mode_t idle_mode = IDLE_NONE;
    int         hold_off = 0;   // receiver holds tready low while this counts down to zero
    int         errors = 0;
    int         cycles = 0;
    int         series_base = 0;

    function automatic void restart_series();
        win_sum = 0;
        win_sqsum = '0;
        win_count = 0;
        win_slot = 0;
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] res, bitv;
        res = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Advance the window by one sample and return the stats it produces.
    function automatic stats_t window_stats(logic signed [SAMPLE_W-1:0] x, logic start);
        stats_t st;
        int w;
        longint xv, oldv, m, num, zq;
        logic [127:0] wide, sq;
        logic [63:0] mag, q, d, dv;
        st = '0;
        w = (win_len == 0) ? 1 : (win_len > MAXW ? MAXW : int'(win_len));
        xv = x;
        if (start) restart_series();
        if (win_slot >= w) win_slot = 0;
        if (win_count >= w) begin
            oldv = win_mem[win_slot];
            win_sum -= oldv;
            win_sqsum -= 64'(oldv * oldv);
        end
        win_mem[win_slot] = x;
        win_sum += xv;
        win_sqsum += 64'(xv * xv);
        win_slot = (win_slot + 1 >= w) ? 0 : win_slot + 1;
        if (win_count < w) win_count++;
        if (win_count >= w) begin
            st.full = 1'b1;
            m = (win_sum * 256) / longint'(w);
            st.mean = m[31:0];
            if (w >= 2) begin
                mag = (win_sum < 0) ? 64'(-win_sum) : 64'(win_sum);
                wide = 128'(w) * 128'(win_sqsum);
                sq = 128'(mag) * 128'(mag);
                wide = (wide - sq) << 16;
                d = 64'(w) * 64'(w) * 64'(w - 1);
                q = 64'(wide / 128'(d));
                dv = root_floor(q) & 64'hFFFF_FFFF;
                st.dev = dv[31:0];
                if (dv != 0) begin
                    num = (xv * 256 - m) * 4096;
                    zq = num / longint'(dv);
                    if (zq > 65535) zq = 65535;
                    if (zq < -65536) zq = -65536;
                    st.z = zq[16:0];
                end
            end
        end
        return st;
    endfunction

    // ---- shared driving tasks ----
    function automatic int idle_pct(bit sender);
        case (idle_mode)
            IDLE_SEND_HEAVY: return sender ? 25 : 59;
            IDLE_RECV_HEAVY: return sender ? 59 : 25;
            default:         return 0;
        endcase
    endfunction

    task automatic send_sample(logic signed [SAMPLE_W-1:0] x, logic start);
        bit rdy;
        while ($urandom_range(99) < idle_pct(1)) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        s_axis_tuser  <= start;
        do begin
            @(negedge clk);
            rdy = s_axis_tready;
            if (rdy) pending_stats.push_back(window_stats(x, start));
            @(posedge clk);
        end while (!rdy);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_stats.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_window(logic [W_W-1:0] len);
        bit rdy;
        s_axis_tvalid <= 1'b0;
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do begin
            @(negedge clk);
            rdy = cfg_ready;
            @(posedge clk);
        end while (!rdy);
        cfg_valid <= 1'b0;
        win_len = len;
        restart_series();
        @(posedge clk);
    endtask

    // Mostly noise around a per-series level, sometimes anything at all.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 10) return SAMPLE_W'($urandom);
        if (r < 14) return ($urandom_range(1) != 0) ? S_MAX : S_MIN;
        if (r < 18) return SAMPLE_W'(series_base);
        return SAMPLE_W'(series_base + int'($urandom_range(2000)) - 1000);
    endfunction

    // ---- receiver: random stalls, long hold-off on request ----
    always @(posedge clk) begin
        if (hold_off > 0) begin
            m_axis_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= idle_pct(0));
    end

    // ---- result checker: output is stable between edges ----
    always @(negedge clk) begin
        stats_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got.mean = m_axis_tdata[31:0];
            got.dev  = m_axis_tdata[63:32];
            got.z    = m_axis_tdata[80:64];
            got.full = m_axis_tuser;
            if (pending_stats.size() == 0) begin
                errors++;
                $display("%0t: unexpected item mean=%h dev=%h z=%h full=%b",
                         $time, got.mean, got.dev, got.z, got.full);
            end
            else begin
                want = pending_stats.pop_front();
                if (got.mean !== want.mean) begin
                    errors++;
                    $display("%0t: mean expected %h actual %h", $time, want.mean, got.mean);
                end
                if (got.dev !== want.dev) begin
                    errors++;
                    $display("%0t: deviation expected %h actual %h", $time, want.dev, got.dev);
                end
                if (got.z !== want.z) begin
                    errors++;
                    $display("%0t: zscore expected %h actual %h", $time, want.z, got.z);
                end
                if (got.full !== want.full) begin
                    errors++;
                    $display("%0t: window_full expected %b actual %b",
                             $time, want.full, got.full);
                end
                if (m_axis_tdata[OUT_DATA_W-1:81] !== '0) begin
                    errors++;
                    $display("%0t: pad bits expected 0 actual %h",
                             $time, m_axis_tdata[OUT_DATA_W-1:81]);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("rolling_window_zscore: mismatch");
            $finish;
        end
    end

    // ---- tests ----
    task automatic test_reset_length();
        // default window of 20 straight out of reset, plus a fresh series
        for (int i = 0; i < 22; i++) send_sample(SAMPLE_W'(i * 1000 - 9000), 1'b0);
        send_sample(S_MAX, 1'b1);
        send_sample(S_MIN, 1'b0);
        stop_sending();
    endtask

    task automatic test_extremes();
        write_window(WL_MIN);           // one-sample window: zero deviation
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b1);
        send_sample(0, 1'b0);
        stop_sending();
        write_window(7'd2);             // widest spread between two samples
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample(-1, 1'b0);
        stop_sending();
        write_window(7'd3);             // constant run: zero deviation
        repeat (4) send_sample(S_MIN, 1'b0);
        send_sample(24'sd5, 1'b1);
        repeat (3) send_sample(24'sd5, 1'b0);
        stop_sending();
        write_window(WL_MAX);
        for (int i = 0; i < 66; i++) send_sample((i % 2) ? S_MAX : S_MIN, 1'b0);
        stop_sending();
    endtask

    task automatic test_backpressure();
        write_window(7'd4);
        series_base = 100000;
        hold_off = 400;                 // output stalls while samples keep coming
        for (int i = 0; i < 10; i++) send_sample(pick_sample(), 1'b0);
        stop_sending();
        drain();                        // sender waits for every result
        for (int i = 0; i < 6; i++) send_sample(pick_sample(), 1'b0);
        stop_sending();
    endtask

    task automatic test_random(idle_mode_t mode, int n);
        int sent;
        logic [W_W-1:0] len;
        idle_mode = mode;
        sent = 0;
        while (sent < n) begin
            case ($urandom_range(9))
                0:       len = WL_MIN;
                1:       len = WL_MAX;
                2, 3:    len = 7'($urandom_range(64, 1));
                default: len = 7'($urandom_range(12, 2));
            endcase
            write_window(len);
            series_base = int'($urandom_range(32'h00FF_FFFF)) - 8388608;
            repeat (int'(len) + $urandom_range(60, 20)) begin
                if ($urandom_range(99) < 3)
                    series_base = int'($urandom_range(32'h00FF_FFFF)) - 8388608;
                send_sample(pick_sample(), $urandom_range(99) < 3);
                sent++;
            end
            if ($urandom_range(3) == 0) stop_sending();
        end
        stop_sending();
    endtask

    initial begin
        win_len = WL_RESET;
        restart_series();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_length();
        test_extremes();
        idle_mode = IDLE_SEND_HEAVY;
        test_backpressure();
        test_random(IDLE_SEND_HEAVY, 590);
        test_random(IDLE_RECV_HEAVY, 590);
        test_random(IDLE_NONE, 590);
        while (pending_stats.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("rolling_window_zscore: match");
        else
            $display("rolling_window_zscore: mismatch");
        $finish;
    end
endmodule

@@ sim.f @@
hw/rtl/rwz_pkg.sv
hw/rtl/rwz_csub.sv
hw/rtl/rolling_window_zscore.sv
hw/rtl/rwz_chk.sv
bench/rolling_window_zscore_test.sv
